// ===== rtl/lps_pkg.sv =====
package lps_pkg;

	localparam int COORD_BITS = 10;
	localparam int ERR_BITS   = COORD_BITS + 2;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_STEP = 1'b1
	} func_t;

	typedef struct packed {
		func_t  func;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
	} cmd_t;

	typedef struct packed {
		coord_t pix_x;
		coord_t pix_y;
		logic   last;
	} pix_t;

	typedef struct packed {
		logic   nonzero;
		logic   y_is_major;
		logic   minor_down;
		coord_t cur_x;
		coord_t cur_y;
		coord_t major_end;
		coord_t delta_major;
		coord_t delta_minor;
		err_t   err;
	} line_setup_t;

endpackage

// ===== rtl/lps_setup.sv =====
module lps_setup (
	input  lps_pkg::cmd_t        cmd,
	output lps_pkg::line_setup_t setup
);

	lps_pkg::coord_t dx;
	lps_pkg::coord_t dy;
	lps_pkg::coord_t xa;
	lps_pkg::coord_t ya;
	lps_pkg::coord_t xb;
	lps_pkg::coord_t yb;
	logic            y_major;
	logic            swap;

	localparam int PadBits = lps_pkg::ERR_BITS - lps_pkg::COORD_BITS;

	always_comb begin
		dx      = (cmd.x_start > cmd.x_end) ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
		dy      = (cmd.y_start > cmd.y_end) ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
		y_major = (dx <= dy);
		swap    = y_major ? (cmd.y_end < cmd.y_start) : (cmd.x_end < cmd.x_start);
		xa      = swap ? cmd.x_end   : cmd.x_start;
		ya      = swap ? cmd.y_end   : cmd.y_start;
		xb      = swap ? cmd.x_start : cmd.x_end;
		yb      = swap ? cmd.y_start : cmd.y_end;

		setup.nonzero     = (dx != '0) || (dy != '0);
		setup.y_is_major  = y_major;
		setup.minor_down  = y_major ? (xb < xa) : (yb < ya);
		setup.cur_x       = xa;
		setup.cur_y       = ya;
		setup.major_end   = y_major ? yb : xb;
		setup.delta_major = y_major ? dy : dx;
		setup.delta_minor = y_major ? dx : dy;
		setup.err         = $signed({{PadBits{1'b0}}, setup.delta_minor})
			- $signed({{PadBits{1'b0}}, setup.delta_major});
	end

endmodule

// ===== rtl/lps_core.sv =====
module lps_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  lps_pkg::func_t       func,
	input  lps_pkg::line_setup_t setup,
	output logic                 active,
	output logic                 out_free,
	output logic                 pix_valid,
	input  logic                 pix_stall,
	output lps_pkg::pix_t        pix
);

	localparam int PadBits = lps_pkg::ERR_BITS - lps_pkg::COORD_BITS;

	lps_pkg::coord_t cur_x_q;
	lps_pkg::coord_t cur_y_q;
	lps_pkg::coord_t major_end_q;
	lps_pkg::coord_t delta_major_q;
	lps_pkg::coord_t delta_minor_q;
	lps_pkg::err_t   err_q;
	logic            y_is_major_q;
	logic            minor_down_q;
	logic            active_q;
	logic            pix_valid_q;
	lps_pkg::pix_t   pix_q;

	logic            emit;
	logic            load;
	logic            is_last;
	logic            err_ge;
	lps_pkg::coord_t major_cur;
	lps_pkg::coord_t minor_cur;
	lps_pkg::coord_t minor_next;
	lps_pkg::err_t   dmaj_ext;
	lps_pkg::err_t   dmin_ext;
	lps_pkg::err_t   err_next;

	always_comb begin
		load       = go && (func == lps_pkg::FUNC_LOAD);
		emit       = go && (func == lps_pkg::FUNC_STEP) && active_q;
		major_cur  = y_is_major_q ? cur_y_q : cur_x_q;
		minor_cur  = y_is_major_q ? cur_x_q : cur_y_q;
		is_last    = (major_cur == major_end_q);
		err_ge     = !err_q[lps_pkg::ERR_BITS-1];
		minor_next = minor_down_q ? minor_cur - 1'b1 : minor_cur + 1'b1;
		dmaj_ext   = $signed({{PadBits{1'b0}}, delta_major_q});
		dmin_ext   = $signed({{PadBits{1'b0}}, delta_minor_q});
		err_next   = err_q + dmin_ext - (err_ge ? dmaj_ext : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			major_end_q   <= '0;
			delta_major_q <= '0;
			delta_minor_q <= '0;
			err_q         <= '0;
			y_is_major_q  <= 1'b0;
			minor_down_q  <= 1'b0;
			active_q      <= 1'b0;
		end else if (load) begin
			if (setup.nonzero) begin
				cur_x_q       <= setup.cur_x;
				cur_y_q       <= setup.cur_y;
				major_end_q   <= setup.major_end;
				delta_major_q <= setup.delta_major;
				delta_minor_q <= setup.delta_minor;
				err_q         <= setup.err;
				y_is_major_q  <= setup.y_is_major;
				minor_down_q  <= setup.minor_down;
				active_q      <= 1'b1;
			end else begin
				active_q <= 1'b0;
			end
		end else if (emit) begin
			if (is_last) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_next;
				if (y_is_major_q) begin
					cur_y_q <= cur_y_q + 1'b1;
					if (err_ge) begin
						cur_x_q <= minor_next;
					end
				end else begin
					cur_x_q <= cur_x_q + 1'b1;
					if (err_ge) begin
						cur_y_q <= minor_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (emit) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q.pix_x <= cur_x_q;
			pix_q.pix_y <= cur_y_q;
			pix_q.last  <= is_last;
		end
	end

	assign active    = active_q;
	assign out_free  = !pix_valid_q || !pix_stall;
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (err_q < dmin_ext) && (err_q >= -dmaj_ext))
		else $error("error term out of range");

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_last |=> !active_q)
		else $error("still active after final pixel");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !pix_valid_q || !pix_stall)
		else $error("held pixel beat overwritten");

	a_major_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> delta_major_q != '0)
		else $error("active line with zero major delta");

endmodule

// ===== rtl/line_pixel_stepper.sv =====
// line_pixel_stepper: integer line rasterizer, one pixel per step beat.
// A step beat passes the input register, then the state update and pixel register,
// before its pixel beat shows; a held pixel beat can stall it in the input register.
// Throughput: one command beat per cycle while not stalled; a held pixel beat stalls step beats.
// Reset (arst_n low): no line loaded, both registers empty, core line state zero.
module line_pixel_stepper (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  lps_pkg::cmd_t cmd,
	output logic          pix_valid,
	input  logic          pix_stall,
	output lps_pkg::pix_t pix
);

	logic                 cmd_valid_s1;
	lps_pkg::cmd_t        cmd_s1;
	lps_pkg::line_setup_t setup;
	logic                 active;
	logic                 out_free;
	logic                 go;

	assign go        = cmd_valid_s1 && ((cmd_s1.func == lps_pkg::FUNC_LOAD) || !active || out_free);
	assign cmd_stall = cmd_valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			cmd_valid_s1 <= 1'b1;
		end else if (go) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	lps_setup u_setup (
		.cmd   (cmd_s1),
		.setup (setup)
	);

	lps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.func      (cmd_s1.func),
		.setup     (setup),
		.active    (active),
		.out_free  (out_free),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

endmodule
